// ----- hdl/kalman_cv_tracker_2d_assert.svh -----
// Assertion macros for the 2-D constant-velocity tracker
`ifndef KALMAN_CV_TRACKER_2D_ASSERT_SVH
`define KALMAN_CV_TRACKER_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define KCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCT_ASSERT(label, clk, rstn, prop, msg)
`define KCT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hdl/kct_pkg.sv -----
// Shared types and constants for the 2-D constant-velocity tracker
package kct_pkg;

    localparam int COORD_BITS = 16;
    localparam int STATE_W    = 48;
    localparam int COV_W      = 32;
    localparam int REG_W      = 28;
    localparam int FRAC_STATE = 16;
    localparam int FRAC_GAIN  = 24;
    localparam int GAIN_W     = FRAC_GAIN + 1;
    localparam int DIV_STEPS  = FRAC_GAIN;
    localparam int MUL_STEPS  = 11;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COV   = 2'd2;

    localparam logic [REG_W-1:0] RST_PROCESS_NOISE = 28'd1678;
    localparam logic [REG_W-1:0] RST_MEASURE_NOISE = 28'd167772;
    localparam logic [REG_W-1:0] RST_INITIAL_COV   = 28'd1677722;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] meas_x;
        logic signed [COORD_BITS-1:0] meas_y;
        logic                         start_of_track;
    } in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pred_x;
        logic signed [COORD_BITS-1:0] pred_y;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_EMIT,
        ST_DIV,
        ST_GAIN,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic              load;
        logic              pred;
        logic              emit;
        logic              div_step;
        logic              gain;
        logic              mul_step;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// ----- hdl/kct_ctrl.sv -----
// Sequencer for the tracker: load, predict, emit, gain division, update multiplies
module kct_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  kct_pkg::stat_t stat,
    output kct_pkg::cmd_t  cmd
);

    kct_pkg::state_t state_reg, state_next;
    logic [kct_pkg::STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kct_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            kct_pkg::ST_IDLE: begin
                if (s_valid) state_next = kct_pkg::ST_PRED;
            end
            kct_pkg::ST_PRED: state_next = kct_pkg::ST_EMIT;
            kct_pkg::ST_EMIT: begin
                if (stat.out_free) state_next = kct_pkg::ST_DIV;
            end
            kct_pkg::ST_DIV: begin
                if (cnt_reg == kct_pkg::STEP_W'(kct_pkg::DIV_STEPS - 1)) begin
                    state_next = kct_pkg::ST_GAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            kct_pkg::ST_GAIN: state_next = kct_pkg::ST_MUL;
            kct_pkg::ST_MUL: begin
                if (cnt_reg == kct_pkg::STEP_W'(kct_pkg::MUL_STEPS)) begin
                    state_next = kct_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = kct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == kct_pkg::ST_IDLE);
        cmd.load     = (state_reg == kct_pkg::ST_IDLE) && s_valid;
        cmd.pred     = (state_reg == kct_pkg::ST_PRED);
        cmd.emit     = (state_reg == kct_pkg::ST_EMIT) && stat.out_free;
        cmd.div_step = (state_reg == kct_pkg::ST_DIV);
        cmd.gain     = (state_reg == kct_pkg::ST_GAIN);
        cmd.mul_step = (state_reg == kct_pkg::ST_MUL);
        cmd.step     = cnt_reg;
    end

endmodule

// ----- hdl/kct_dp.sv -----
// Datapath for the tracker: state, covariance, gain divider, shared multiplier, output register
module kct_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [kct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kct_pkg::REG_W-1:0]       cfg_data,
    input  kct_pkg::in_t                    s_data,
    output kct_pkg::out_t                   m_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    input  kct_pkg::cmd_t                   cmd,
    output kct_pkg::stat_t                  stat
);

    localparam int SW = kct_pkg::STATE_W;
    localparam int CW = kct_pkg::COV_W;
    localparam int GW = kct_pkg::GAIN_W;
    localparam int FG = kct_pkg::FRAC_GAIN;
    localparam int PW = GW + CW;

    function automatic logic signed [SW-1:0] sat48(input logic signed [SW:0] v);
        logic signed [SW-1:0] res;
        if (v[SW] != v[SW-1]) begin
            res = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            res = v[SW-1:0];
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] satcov(input logic [CW+2:0] v);
        return (v[CW+2:CW] != '0) ? {CW{1'b1}} : v[CW-1:0];
    endfunction

    logic [kct_pkg::REG_W-1:0] q_reg, r_reg, p0_reg;
    logic signed [SW-1:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [CW-1:0] pp_reg, pv_reg, vv_reg;
    logic [CW-1:0] a_reg, b_reg, c_reg;
    logic [CW:0] s_reg, rem_p_reg, rem_v_reg;
    logic [FG-1:0] qp_reg, qv_reg;
    logic [GW-1:0] kp_reg, kv_reg;
    logic signed [kct_pkg::COORD_BITS-1:0] zx_reg, zy_reg;
    logic [SW-1:0] ex_reg, ey_reg;
    logic ex_neg_reg, ey_neg_reg;
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] acc_reg;
    kct_pkg::out_t out_reg;
    logic out_valid_reg;

    logic signed [SW-1:0] npx, npy;
    logic [CW-1:0] na, nb, nc;
    logic signed [SW-1:0] ex_s, ey_s;
    logic [CW+1:0] tp, tv;
    logic [GW-1:0] opk;
    logic [CW-1:0] opc;
    logic [kct_pkg::STEP_W-1:0] cj;
    logic [SW-1:0] term;
    logic cneg;
    logic signed [SW-1:0] ctgt, cupd;
    logic signed [SW:0] csum;
    logic [CW-1:0] dcov;
    kct_pkg::out_t pred_o;

    function automatic logic signed [kct_pkg::COORD_BITS-1:0] coord_out(
        input logic signed [SW-1:0] p);
        logic signed [SW-kct_pkg::FRAC_STATE-1:0] t;
        logic signed [kct_pkg::COORD_BITS-1:0] hi;
        logic signed [kct_pkg::COORD_BITS-1:0] lo;
        t  = p[SW-1:kct_pkg::FRAC_STATE];
        hi = {1'b0, {(kct_pkg::COORD_BITS-1){1'b1}}};
        lo = {1'b1, {(kct_pkg::COORD_BITS-1){1'b0}}};
        if (p[SW-1] && (p[kct_pkg::FRAC_STATE-1:0] != '0)) t = t + 1'b1;
        if (t > (SW-kct_pkg::FRAC_STATE)'(hi)) return hi;
        if (t < (SW-kct_pkg::FRAC_STATE)'(lo)) return lo;
        return t[kct_pkg::COORD_BITS-1:0];
    endfunction

    function automatic logic signed [SW-1:0] innov(input logic signed [kct_pkg::COORD_BITS-1:0] z,
                                                  input logic signed [SW-1:0] p);
        logic signed [SW:0] zz;
        zz = (SW+1)'($signed({z, {kct_pkg::FRAC_STATE{1'b0}}}));
        return sat48(zz - {p[SW-1], p});
    endfunction

    always_comb begin
        npx = sat48({pos_x_reg[SW-1], pos_x_reg} + {vel_x_reg[SW-1], vel_x_reg});
        npy = sat48({pos_y_reg[SW-1], pos_y_reg} + {vel_y_reg[SW-1], vel_y_reg});
        na  = satcov((CW+3)'(pp_reg) + (CW+3)'({pv_reg, 1'b0})
                     + (CW+3)'(vv_reg) + (CW+3)'(q_reg));
        nb  = satcov((CW+3)'(pv_reg) + (CW+3)'(vv_reg));
        nc  = satcov((CW+3)'(vv_reg) + (CW+3)'(q_reg));
        ex_s = innov(zx_reg, pos_x_reg);
        ey_s = innov(zy_reg, pos_y_reg);
        pred_o.pred_x = coord_out(pos_x_reg);
        pred_o.pred_y = coord_out(pos_y_reg);
        tp = {rem_p_reg, 1'b0};
        tv = {rem_v_reg, 1'b0};
    end

    always_comb begin
        opk = '0;
        opc = '0;
        unique case (cmd.step)
            5'd0: begin opk = kp_reg; opc = CW'(ex_reg[SW-1:FG]); end
            5'd1: begin opk = kp_reg; opc = CW'(ex_reg[FG-1:0]); end
            5'd2: begin opk = kv_reg; opc = CW'(ex_reg[SW-1:FG]); end
            5'd3: begin opk = kv_reg; opc = CW'(ex_reg[FG-1:0]); end
            5'd4: begin opk = kp_reg; opc = CW'(ey_reg[SW-1:FG]); end
            5'd5: begin opk = kp_reg; opc = CW'(ey_reg[FG-1:0]); end
            5'd6: begin opk = kv_reg; opc = CW'(ey_reg[SW-1:FG]); end
            5'd7: begin opk = kv_reg; opc = CW'(ey_reg[FG-1:0]); end
            5'd8: begin opk = kp_reg; opc = a_reg; end
            5'd9: begin opk = kp_reg; opc = b_reg; end
            5'd10: begin opk = kv_reg; opc = b_reg; end
            default: begin opk = '0; opc = '0; end
        endcase
    end

    always_comb begin
        cj   = cmd.step - 1'b1;
        term = acc_reg + SW'(prod_reg[PW-1:FG]);
        dcov = prod_reg[FG+CW-1:FG];
        cneg = cj[2] ? ey_neg_reg : ex_neg_reg;
        unique case (cj[2:1])
            2'd0: ctgt = pos_x_reg;
            2'd1: ctgt = vel_x_reg;
            2'd2: ctgt = pos_y_reg;
            default: ctgt = vel_y_reg;
        endcase
        csum = cneg ? ({ctgt[SW-1], ctgt} - {1'b0, term})
                    : ({ctgt[SW-1], ctgt} + {1'b0, term});
        cupd = sat48(csum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg  <= kct_pkg::RST_PROCESS_NOISE;
            r_reg  <= kct_pkg::RST_MEASURE_NOISE;
            p0_reg <= kct_pkg::RST_INITIAL_COV;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                kct_pkg::CFG_PROCESS_NOISE: q_reg  <= cfg_data;
                kct_pkg::CFG_MEASURE_NOISE: r_reg  <= cfg_data;
                kct_pkg::CFG_INITIAL_COV:   p0_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            pp_reg    <= CW'(kct_pkg::RST_INITIAL_COV);
            pv_reg    <= '0;
            vv_reg    <= CW'(kct_pkg::RST_INITIAL_COV);
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load && s_data.start_of_track) begin
                pos_x_reg <= SW'($signed({s_data.meas_x, {kct_pkg::FRAC_STATE{1'b0}}}));
                pos_y_reg <= SW'($signed({s_data.meas_y, {kct_pkg::FRAC_STATE{1'b0}}}));
                vel_x_reg <= '0;
                vel_y_reg <= '0;
                pp_reg    <= CW'(p0_reg);
                pv_reg    <= '0;
                vv_reg    <= CW'(p0_reg);
            end
            if (cmd.pred) begin
                pos_x_reg <= npx;
                pos_y_reg <= npy;
            end
            if (cmd.mul_step && (cmd.step != '0)) begin
                unique case (cj)
                    5'd1: pos_x_reg <= cupd;
                    5'd3: vel_x_reg <= cupd;
                    5'd5: pos_y_reg <= cupd;
                    5'd7: vel_y_reg <= cupd;
                    5'd8: pp_reg <= a_reg - dcov;
                    5'd9: pv_reg <= b_reg - dcov;
                    5'd10: vv_reg <= (dcov > c_reg) ? '0 : (c_reg - dcov);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            zx_reg <= s_data.meas_x;
            zy_reg <= s_data.meas_y;
        end
        if (cmd.pred) begin
            a_reg <= na;
            b_reg <= nb;
            c_reg <= nc;
            s_reg <= (CW+1)'(na) + (CW+1)'(r_reg);
        end
        if (cmd.emit) begin
            out_reg    <= pred_o;
            rem_p_reg  <= {1'b0, a_reg};
            rem_v_reg  <= {1'b0, b_reg};
            ex_neg_reg <= ex_s[SW-1];
            ey_neg_reg <= ey_s[SW-1];
            ex_reg     <= ex_s[SW-1] ? SW'(-ex_s) : SW'(ex_s);
            ey_reg     <= ey_s[SW-1] ? SW'(-ey_s) : SW'(ey_s);
        end
        if (cmd.div_step) begin
            if (tp >= (CW+2)'(s_reg)) begin
                rem_p_reg <= (CW+1)'(tp - (CW+2)'(s_reg));
                qp_reg    <= {qp_reg[FG-2:0], 1'b1};
            end else begin
                rem_p_reg <= tp[CW:0];
                qp_reg    <= {qp_reg[FG-2:0], 1'b0};
            end
            if (tv >= (CW+2)'(s_reg)) begin
                rem_v_reg <= (CW+1)'(tv - (CW+2)'(s_reg));
                qv_reg    <= {qv_reg[FG-2:0], 1'b1};
            end else begin
                rem_v_reg <= tv[CW:0];
                qv_reg    <= {qv_reg[FG-2:0], 1'b0};
            end
        end
        if (cmd.gain) begin
            if (s_reg == '0) begin
                kp_reg <= '0;
                kv_reg <= '0;
            end else begin
                kp_reg <= ({1'b0, a_reg} >= s_reg) ? GW'(1 << FG) : {1'b0, qp_reg};
                kv_reg <= ({1'b0, b_reg} >= s_reg) ? GW'(1 << FG) : {1'b0, qv_reg};
            end
        end
        if (cmd.mul_step) begin
            prod_reg <= PW'(opk) * PW'(opc);
            if ((cmd.step != '0) && !cj[0] && !cj[3]) acc_reg <= prod_reg[SW-1:0];
        end
    end

    assign m_data        = out_reg;
    assign m_valid       = out_valid_reg;
    assign stat.out_free = !out_valid_reg || m_ready;

endmodule

// ----- hdl/kalman_cv_tracker_2d.sv -----
// 2-D constant-velocity Kalman tracker, top level
// The prediction is formed in the predict step and registered at the output in the emit step.
// The block takes one item at a time: the 24-step gain divider and the
// 11 products through the one shared 25x32 multiplier finish before it takes the next.
// A held result stalls the block in its emit step until the output transfer.
// Reset (aresetn low, synchronous) restores the registers and the track state.
`include "kalman_cv_tracker_2d_assert.svh"
module kalman_cv_tracker_2d (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kct_pkg::REG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  kct_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output kct_pkg::out_t                 m_data
);

    kct_pkg::cmd_t  cmd;
    kct_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    kct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kct_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    `KCT_ASSERT(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "second transfer while busy")
    `KCT_ASSERT(a_cmd_exclusive, aclk, aresetn, $onehot0({cmd.pred, cmd.emit, cmd.div_step, cmd.gain, cmd.mul_step}), "overlapping commands")
    `KCT_ASSERT(a_emit_free, aclk, aresetn, cmd.emit |-> stat.out_free, "emit into occupied output")
    `KCT_ASSERT(a_valid_source, aclk, aresetn, $rose(m_valid) |-> $past(cmd.emit), "result without emit")

endmodule

// ----- sim/tb_kalman_cv_tracker_2d.sv -----
// Self-checking testbench for the 2-D constant-velocity Kalman tracker
module tb_kalman_cv_tracker_2d;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [kct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kct_pkg::REG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    kct_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    kct_pkg::out_t m_data;

    always #4 aclk = ~aclk;

    kalman_cv_tracker_2d u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    localparam longint S48_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_LO = -S48_HI - 1;
    localparam longint COV_HI = 64'hFFFF_FFFF;

    logic [kct_pkg::REG_W-1:0] q_noise, r_noise, p0_cov;
    longint trk_px, trk_py, trk_vx, trk_vy;
    longint unsigned trk_pp, trk_pv, trk_vv;

    kct_pkg::in_t pending_items[$];
    kct_pkg::out_t expected_preds[$];
    int fail_count = 0;
    bit hold_sink = 1'b0;
    int sink_hold_cycles = 0;
    int src_gap = 0;
    int sink_gap = 0;

    function automatic longint sat48(longint v);
        if (v > S48_HI) return S48_HI;
        if (v < S48_LO) return S48_LO;
        return v;
    endfunction

    function automatic longint unsigned sat_cov(longint unsigned v);
        return (v > COV_HI) ? COV_HI : v;
    endfunction

    function automatic logic signed [kct_pkg::COORD_BITS-1:0] to_coord(longint p);
        longint v;
        v = p / 65536;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[kct_pkg::COORD_BITS-1:0];
    endfunction

    function automatic longint apply_gain(longint e, longint unsigned k);
        longint unsigned m, r;
        m = (e < 0) ? longint'(-e) : longint'(e);
        r = (m >> 24) * k + (((m & 64'hFF_FFFF) * k) >> 24);
        return (e < 0) ? -longint'(r) : longint'(r);
    endfunction

    task automatic correct_axis(inout longint pos, inout longint vel, input longint z,
                                input longint unsigned kp, input longint unsigned kv);
        longint e;
        e = sat48(z * 65536 - pos);
        pos = sat48(pos + apply_gain(e, kp));
        vel = sat48(vel + apply_gain(e, kv));
    endtask

    task automatic track_step(input kct_pkg::in_t it);
        longint zx, zy;
        longint unsigned a, b, c, s, kp, kv, dc;
        kct_pkg::out_t o;
        zx = longint'(it.meas_x);
        zy = longint'(it.meas_y);
        if (it.start_of_track) begin
            trk_px = zx * 65536; trk_py = zy * 65536;
            trk_vx = 0; trk_vy = 0;
            trk_pp = p0_cov; trk_pv = 0; trk_vv = p0_cov;
        end
        trk_px = sat48(trk_px + trk_vx);
        trk_py = sat48(trk_py + trk_vy);
        a = sat_cov(trk_pp + 2 * trk_pv + trk_vv + q_noise);
        b = sat_cov(trk_pv + trk_vv);
        c = sat_cov(trk_vv + q_noise);
        o.pred_x = to_coord(trk_px);
        o.pred_y = to_coord(trk_py);
        expected_preds.insert(expected_preds.size(), o);
        s = a + r_noise;
        if (s == 0) begin
            kp = 0; kv = 0;
        end else begin
            kp = (a << 24) / s;
            kv = (b << 24) / s;
            if (kp > (64'd1 << 24)) kp = 64'd1 << 24;
            if (kv > (64'd1 << 24)) kv = 64'd1 << 24;
        end
        correct_axis(trk_px, trk_vx, zx, kp, kv);
        correct_axis(trk_py, trk_vy, zy, kp, kv);
        trk_pp = (a - ((kp * a) >> 24)) & COV_HI;
        trk_pv = (b - ((kp * b) >> 24)) & COV_HI;
        dc = (kv * b) >> 24;
        trk_vv = (dc > c) ? 0 : ((c - dc) & COV_HI);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            track_step(s_data);
            void'(pending_items.pop_front());
        end
        if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= pending_items[0];
                src_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold
    always @(posedge aclk) begin
        if (sink_hold_cycles > 0) begin
            sink_hold_cycles <= sink_hold_cycles - 1;
            hold_sink <= 1'b1;
        end else begin
            hold_sink <= 1'b0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (expected_preds.size() == 0) begin
                $error("unexpected transfer pred_x=%0d pred_y=%0d", m_data.pred_x,
                       m_data.pred_y);
                fail_count++;
            end else begin
                if (m_data.pred_x !== expected_preds[0].pred_x) begin
                    $error("pred_x expected %0d actual %0d", expected_preds[0].pred_x,
                           m_data.pred_x);
                    fail_count++;
                end
                if (m_data.pred_y !== expected_preds[0].pred_y) begin
                    $error("pred_y expected %0d actual %0d", expected_preds[0].pred_y,
                           m_data.pred_y);
                    fail_count++;
                end
                void'(expected_preds.pop_front());
            end
        end
        if (hold_sink) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_gap <= pick_gap();
        end
    end

    task automatic add_item(input int x, input int y, input bit st);
        kct_pkg::in_t it;
        it.meas_x = x[kct_pkg::COORD_BITS-1:0];
        it.meas_y = y[kct_pkg::COORD_BITS-1:0];
        it.start_of_track = st;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_valid || expected_preds.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [kct_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kct_pkg::REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == kct_pkg::CFG_PROCESS_NOISE) q_noise = val;
        else if (idx == kct_pkg::CFG_MEASURE_NOISE) r_noise = val;
        else if (idx == kct_pkg::CFG_INITIAL_COV) p0_cov = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_tracks(input int n);
        int x, y, vx, vy;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_item($urandom, $urandom, $urandom_range(0, 1));
            end else begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
                vx = $urandom_range(0, 400) - 200;
                vy = $urandom_range(0, 400) - 200;
                add_item(x, y, 1'b1);
                for (int j = $urandom_range(3, 30); j > 0 && i < n; j--, i++) begin
                    x += vx + $urandom_range(0, 6) - 3;
                    y += vy + $urandom_range(0, 6) - 3;
                    if (x > 32767 || x < -32768) x = -x / 2;
                    if (y > 32767 || y < -32768) y = -y / 2;
                    add_item(x, y, 1'b0);
                end
            end
        end
    endtask

    initial begin
        logic [kct_pkg::REG_W-1:0] cfg_sets[5][3];
        q_noise = kct_pkg::RST_PROCESS_NOISE;
        r_noise = kct_pkg::RST_MEASURE_NOISE;
        p0_cov = kct_pkg::RST_INITIAL_COV;
        trk_px = 0; trk_py = 0; trk_vx = 0; trk_vy = 0;
        trk_pp = kct_pkg::RST_INITIAL_COV; trk_pv = 0; trk_vv = kct_pkg::RST_INITIAL_COV;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_item(100, -100, 1'b0);
        add_item(32767, -32768, 1'b1);
        add_item(32767, -32768, 1'b0);
        add_item(-32768, 32767, 1'b0);
        add_item(0, 0, 1'b1);
        add_item(-1, 1, 1'b0);
        add_item(-32768, -32768, 1'b1);
        add_item(32767, 32767, 1'b0);
        add_item(5, 5, 1'b0);
        drain();

        // zero innovation variance
        write_reg(kct_pkg::CFG_PROCESS_NOISE, '0);
        write_reg(kct_pkg::CFG_MEASURE_NOISE, '0);
        write_reg(kct_pkg::CFG_INITIAL_COV, '0);
        add_item(10, 20, 1'b1);
        add_item(30, -40, 1'b0);
        add_item(-32768, 32767, 1'b0);
        drain();

        cfg_sets[0] = '{kct_pkg::RST_PROCESS_NOISE, kct_pkg::RST_MEASURE_NOISE,
                        kct_pkg::RST_INITIAL_COV};
        cfg_sets[1] = '{28'hFFFFFFF, 28'hFFFFFFF, 28'hFFFFFFF};
        cfg_sets[2] = '{28'd0, 28'hFFFFFFF, 28'd1};
        cfg_sets[3] = '{28'hFFFFFFF, 28'd0, 28'hFFFFFFF};
        cfg_sets[4] = '{28'd5000, 28'd20000, 28'd3000000};
        for (int p = 0; p < 5; p++) begin
            write_reg(kct_pkg::CFG_PROCESS_NOISE, cfg_sets[p][0]);
            write_reg(kct_pkg::CFG_MEASURE_NOISE, cfg_sets[p][1]);
            write_reg(kct_pkg::CFG_INITIAL_COV, cfg_sets[p][2]);
            random_tracks(300);
            if (p == 1) begin
                sink_hold_cycles = 600;
            end
            drain();
        end
        write_reg(kct_pkg::CFG_PROCESS_NOISE, kct_pkg::REG_W'($urandom));
        write_reg(kct_pkg::CFG_MEASURE_NOISE, kct_pkg::REG_W'($urandom));
        write_reg(kct_pkg::CFG_INITIAL_COV, kct_pkg::REG_W'($urandom));
        random_tracks(400);
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
